[hdl/sapo_pkg.sv]
// Package for the separating-axis interval test core.
// Holds the field widths, the payload types and the register map.
// Depends on nothing; every other file imports it.
package sapo_pkg;

    // Vertex coordinates in signed Q16.16, axis components in signed Q2.16.
    localparam int COORD_WIDTH = 32;
    localparam int AXIS_WIDTH  = 18;

    // Projections and reported bounds are signed Q20.16 in 36 bits.
    localparam int BOUND_WIDTH = 36;

    // Fraction bits of the axis that the projection drops again.
    localparam int AXIS_FRAC = 16;

    // Widths of the dot product terms and their sum.
    localparam int PROD_WIDTH  = COORD_WIDTH + AXIS_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int SHIFT_WIDTH = SUM_WIDTH - AXIS_FRAC;
    localparam int EXT_WIDTH   = (SHIFT_WIDTH > BOUND_WIDTH) ? SHIFT_WIDTH : BOUND_WIDTH;

    // Configuration port.
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 4;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [BOUND_WIDTH-1:0] bound_t;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_AXIS_X = 2'd0,
        REG_AXIS_Y = 2'd1,
        REG_AXIS_Z = 2'd2,
        REG_NONE   = 2'd3
    } reg_index_t;

    // Reset value of the x component is 1.0; only its low bits are kept.
    localparam axis_t AXIS_X_RESET = AXIS_WIDTH'(32'd65536);
    localparam axis_t AXIS_Y_RESET = '0;
    localparam axis_t AXIS_Z_RESET = '0;

endpackage

[hdl/sat_axis_projection_overlap_core.sv]
// Top level of the separating-axis interval test core.
// Projects vertices onto the configured axis, tracks per-shape bounds and reports overlap.
// Depends on sapo_pkg.
//
//  Channel   | Handshake                   | Payload
//  ----------+-----------------------------+---------------------------------------------
//  vertex    | vertex_valid / vertex_stall | set_select, vertex_x/y/z, last_vertex
//  result    | result_valid / result_stall | overlap, set_empty, lowest_a .. highest_b
//  config    | psel, penable, pready       | paddr, pwrite, pwdata, prdata
//
// One vertex is accepted per cycle while vertex_stall is low, because every stage can hand its item on in each cycle.
// A result appears on the result port after its last vertex is accepted:
// it passes the input, product, projection, bound capture and output registers.
// rst_n clears all valid flags and the seen flags and loads the axis reset values.
// A stalled result holds the output register; each stage keeps accepting while
// the stage behind it is empty or moving.
module sat_axis_projection_overlap_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Vertex channel.
    input  logic                        vertex_valid,
    output logic                        vertex_stall,
    input  logic                        set_select,
    input  sapo_pkg::coord_t            vertex_x,
    input  sapo_pkg::coord_t            vertex_y,
    input  sapo_pkg::coord_t            vertex_z,
    input  logic                        last_vertex,
    // Result channel.
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        overlap,
    output logic                        set_empty,
    output sapo_pkg::bound_t            lowest_a,
    output sapo_pkg::bound_t            highest_a,
    output sapo_pkg::bound_t            lowest_b,
    output sapo_pkg::bound_t            highest_b,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sapo_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [sapo_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [sapo_pkg::DATA_WIDTH-1:0] prdata,
    output logic                        pready
);
    import sapo_pkg::*;

    localparam logic signed [EXT_WIDTH-1:0] PROJ_MAX =
        {{(EXT_WIDTH-BOUND_WIDTH+1){1'b0}}, {(BOUND_WIDTH-1){1'b1}}};
    localparam logic signed [EXT_WIDTH-1:0] PROJ_MIN =
        {{(EXT_WIDTH-BOUND_WIDTH+1){1'b1}}, {(BOUND_WIDTH-1){1'b0}}};

    // Configuration registers.
    axis_t      axis_x_reg, axis_y_reg, axis_z_reg;
    reg_index_t cfg_index;
    logic       cfg_write;

    // Pipeline stage registers.
    logic       s1_valid_reg, s1_sel_reg, s1_last_reg;
    coord_t     s1_x_reg, s1_y_reg, s1_z_reg;
    logic       s2_valid_reg, s2_sel_reg, s2_last_reg;
    prod_t      s2_px_reg, s2_py_reg, s2_pz_reg;
    logic       s3_valid_reg, s3_sel_reg, s3_last_reg;
    bound_t     s3_proj_reg;

    // Running bounds per shape.
    bound_t     min_a_reg, max_a_reg, min_b_reg, max_b_reg;
    bound_t     min_a_next, max_a_next, min_b_next, max_b_next;
    logic       seen_a_reg, seen_b_reg, seen_a_next, seen_b_next;

    // Captured bounds of a finished test.
    logic       cap_valid_reg, cap_seen_a_reg, cap_seen_b_reg;
    bound_t     cap_min_a_reg, cap_max_a_reg, cap_min_b_reg, cap_max_b_reg;

    // Output register.
    logic       out_valid_reg, overlap_reg, set_empty_reg;
    bound_t     lowest_a_reg, highest_a_reg, lowest_b_reg, highest_b_reg;

    // Handshake chain.
    logic       out_ready, cap_ready, s3_ready, s2_ready, s1_ready, s3_fire;

    // Datapath intermediates.
    prod_t                          px_next, py_next, pz_next;
    logic signed [SUM_WIDTH-1:0]    sum;
    logic signed [SHIFT_WIDTH-1:0]  shifted;
    logic signed [EXT_WIDTH-1:0]    shifted_ext;
    bound_t                         proj_next;
    bound_t                         lo_bound, hi_bound;
    logic                           both_seen;

    // Configuration write decode and read mux.
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (cfg_index)
            REG_AXIS_X: prdata = DATA_WIDTH'(axis_x_reg);
            REG_AXIS_Y: prdata = DATA_WIDTH'(axis_y_reg);
            REG_AXIS_Z: prdata = DATA_WIDTH'(axis_z_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= AXIS_X_RESET;
            axis_y_reg <= AXIS_Y_RESET;
            axis_z_reg <= AXIS_Z_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_AXIS_X: axis_x_reg <= axis_t'(pwdata[AXIS_WIDTH-1:0]);
                REG_AXIS_Y: axis_y_reg <= axis_t'(pwdata[AXIS_WIDTH-1:0]);
                REG_AXIS_Z: axis_z_reg <= axis_t'(pwdata[AXIS_WIDTH-1:0]);
                default:    ;
            endcase
        end
    end

    // Each stage moves when the stage behind it is empty or moving.
    assign out_ready    = !out_valid_reg || !result_stall;
    assign cap_ready    = !cap_valid_reg || out_ready;
    assign s3_ready     = !s3_valid_reg || cap_ready;
    assign s3_fire      = s3_valid_reg && cap_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign vertex_stall = !s1_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= vertex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && vertex_valid)
        begin
            s1_sel_reg  <= set_select;
            s1_last_reg <= last_vertex;
            s1_x_reg    <= vertex_x;
            s1_y_reg    <= vertex_y;
            s1_z_reg    <= vertex_z;
        end
    end

    // The three products of the dot product, each exact.
    assign px_next = prod_t'(s1_x_reg) * prod_t'(axis_x_reg);
    assign py_next = prod_t'(s1_y_reg) * prod_t'(axis_y_reg);
    assign pz_next = prod_t'(s1_z_reg) * prod_t'(axis_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_sel_reg  <= s1_sel_reg;
            s2_last_reg <= s1_last_reg;
            s2_px_reg   <= px_next;
            s2_py_reg   <= py_next;
            s2_pz_reg   <= pz_next;
        end
    end

    // Sum, drop the axis fraction with floor rounding, then saturate to the bound width.
    assign sum = SUM_WIDTH'(s2_px_reg) + SUM_WIDTH'(s2_py_reg) + SUM_WIDTH'(s2_pz_reg);
    assign shifted     = sum[SUM_WIDTH-1:AXIS_FRAC];
    assign shifted_ext = EXT_WIDTH'(shifted);

    always_comb
    begin
        priority if (shifted_ext > PROJ_MAX)
            proj_next = PROJ_MAX[BOUND_WIDTH-1:0];
        else if (shifted_ext < PROJ_MIN)
            proj_next = PROJ_MIN[BOUND_WIDTH-1:0];
        else
            proj_next = shifted_ext[BOUND_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_sel_reg  <= s2_sel_reg;
            s3_last_reg <= s2_last_reg;
            s3_proj_reg <= proj_next;
        end
    end

    // Running bounds: the first vertex of a shape sets both of its bounds.
    always_comb
    begin
        min_a_next  = min_a_reg;
        max_a_next  = max_a_reg;
        min_b_next  = min_b_reg;
        max_b_next  = max_b_reg;
        seen_a_next = seen_a_reg;
        seen_b_next = seen_b_reg;
        if (s3_sel_reg)
        begin
            if (!seen_b_reg || s3_proj_reg < min_b_reg)
                min_b_next = s3_proj_reg;
            if (!seen_b_reg || s3_proj_reg > max_b_reg)
                max_b_next = s3_proj_reg;
            seen_b_next = 1'b1;
        end
        else
        begin
            if (!seen_a_reg || s3_proj_reg < min_a_reg)
                min_a_next = s3_proj_reg;
            if (!seen_a_reg || s3_proj_reg > max_a_reg)
                max_a_next = s3_proj_reg;
            seen_a_next = 1'b1;
        end
    end

    // Seen flags clear once a test is captured.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_a_reg <= 1'b0;
            seen_b_reg <= 1'b0;
        end
        else if (s3_fire)
        begin
            seen_a_reg <= seen_a_next && !s3_last_reg;
            seen_b_reg <= seen_b_next && !s3_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_fire)
        begin
            min_a_reg <= min_a_next;
            max_a_reg <= max_a_next;
            min_b_reg <= min_b_next;
            max_b_reg <= max_b_next;
        end
    end

    // Capture register for the bounds of a finished test.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg <= 1'b0;
        end
        else if (cap_ready)
        begin
            cap_valid_reg <= s3_fire && s3_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_fire && s3_last_reg)
        begin
            cap_seen_a_reg <= seen_a_next;
            cap_seen_b_reg <= seen_b_next;
            cap_min_a_reg  <= min_a_next;
            cap_max_a_reg  <= max_a_next;
            cap_min_b_reg  <= min_b_next;
            cap_max_b_reg  <= max_b_next;
        end
    end

    // Interval intersection: larger of the minima against smaller of the maxima.
    assign both_seen = cap_seen_a_reg && cap_seen_b_reg;
    assign lo_bound  = (cap_min_a_reg > cap_min_b_reg) ? cap_min_a_reg : cap_min_b_reg;
    assign hi_bound  = (cap_max_a_reg < cap_max_b_reg) ? cap_max_a_reg : cap_max_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= cap_valid_reg;
        end
    end

    // Bounds of a shape with no vertex read as zero.
    always_ff @(posedge clk)
    begin
        if (out_ready && cap_valid_reg)
        begin
            overlap_reg   <= both_seen && (lo_bound <= hi_bound);
            set_empty_reg <= !both_seen;
            lowest_a_reg  <= cap_seen_a_reg ? cap_min_a_reg : '0;
            highest_a_reg <= cap_seen_a_reg ? cap_max_a_reg : '0;
            lowest_b_reg  <= cap_seen_b_reg ? cap_min_b_reg : '0;
            highest_b_reg <= cap_seen_b_reg ? cap_max_b_reg : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign overlap      = overlap_reg;
    assign set_empty    = set_empty_reg;
    assign lowest_a     = lowest_a_reg;
    assign highest_a    = highest_a_reg;
    assign lowest_b     = lowest_b_reg;
    assign highest_b    = highest_b_reg;

endmodule

[hdl/sapo_checker.sv]
// Port-level checks for the separating-axis interval test core.
// Watches the result channel only; attached to the top level by the bind below.
// Depends on sapo_pkg and sat_axis_projection_overlap_core.
module sapo_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                result_valid,
    input  logic                result_stall,
    input  logic                overlap,
    input  logic                set_empty,
    input  sapo_pkg::bound_t    lowest_a,
    input  sapo_pkg::bound_t    highest_a,
    input  sapo_pkg::bound_t    lowest_b,
    input  sapo_pkg::bound_t    highest_b
);
    import sapo_pkg::*;

    bound_t lo_bound, hi_bound;

    assign lo_bound = (lowest_a > lowest_b) ? lowest_a : lowest_b;
    assign hi_bound = (highest_a < highest_b) ? highest_a : highest_b;

    // A stalled item stays on the port; its overlap, set_empty, lowest_a and highest_b stay unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(overlap)
            && $stable(set_empty) && $stable(lowest_a) && $stable(highest_b))
    else $error("stalled result item changed");

    // An empty shape never reports overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && set_empty |-> !overlap)
    else $error("overlap reported with an empty shape");

    // Each shape's interval is ordered when both shapes are present.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !set_empty |-> lowest_a <= highest_a && lowest_b <= highest_b)
    else $error("minimum above maximum in result item");

    // The overlap flag agrees with the reported bounds when both shapes are present.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !set_empty |-> overlap == (lo_bound <= hi_bound))
    else $error("overlap flag disagrees with the bounds");

endmodule

bind sat_axis_projection_overlap_core sapo_checker u_sapo_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .overlap      (overlap),
    .set_empty    (set_empty),
    .lowest_a     (lowest_a),
    .highest_a    (highest_a),
    .lowest_b     (lowest_b),
    .highest_b    (highest_b)
);
